FILE: rtl/core/most_frequent_letter_histogram_core_defines.svh
// assertion macros for the letter histogram checker
// expects clk_i and rst_ni in the scope of each use
`ifndef MOST_FREQUENT_LETTER_HISTOGRAM_CORE_DEFINES_SVH
`define MOST_FREQUENT_LETTER_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication
`define MFLH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mflh_pkg.sv
// shared types, constants and helpers for the letter histogram
// no dependencies
package mflh_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int COUNT_WIDTH   = 16;
  localparam int LETTER_W      = 5;
  localparam int MASK_W        = 26;
  localparam int IDX_W         = $clog2(ALPHABET_SIZE);
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(ALPHABET_SIZE - 1);

  localparam logic KIND_COUNT  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic REG_EXCLUDED = 1'b0;

  typedef struct packed {
    logic                kind;
    logic [LETTER_W-1:0] letter;
  } mflh_in_t;

  typedef struct packed {
    logic [LETTER_W-1:0] best_letter;
    logic                found;
  } mflh_out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mflh_rd_t;

  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       addr;
    logic [COUNT_WIDTH-1:0] data;
  } mflh_wr_t;

  function automatic logic [MASK_W-1:0] keep_mask();
    logic [MASK_W-1:0] k;
    for (int i = 0; i < MASK_W; i++) begin
      k[i] = (i < ALPHABET_SIZE);
    end
    return k;
  endfunction

  function automatic logic is_excl(logic [MASK_W-1:0] mask, logic [IDX_W-1:0] idx);
    logic r;
    r = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (32'(idx) == i) r = mask[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mflh_cnt_ram.sv
// count memory: one write port, one registered read port, per-entry valid bits
// forwards the write that lands at the same edge as a read; uses mflh_pkg
module mflh_cnt_ram
  import mflh_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mflh_rd_t               rd_i,
  input  mflh_wr_t               wr_i,
  input  logic                   clr_i,
  output logic [COUNT_WIDTH-1:0] rd_data_o
);

  logic [COUNT_WIDTH-1:0] mem_q [ALPHABET_SIZE];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic [ALPHABET_SIZE-1:0] vld_q;
  logic                   rd_vld_q;
  logic [IDX_W-1:0]       rd_addr_q;
  mflh_wr_t               fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    if (rd_i.en) begin
      rdata_q   <= mem_q[rd_i.addr];
      rd_addr_q <= rd_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= '0;
    end else begin
      fwd_q <= wr_i;
      if (rd_i.en) rd_vld_q <= vld_q[rd_i.addr];
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  // entry never written since the last clear reads as zero
  always_comb begin
    if (fwd_q.en && fwd_q.addr == rd_addr_q) begin
      rd_data_o = fwd_q.data;
    end else if (rd_vld_q) begin
      rd_data_o = rdata_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

FILE: rtl/core/mflh_scan.sv
// finish sequencer: walks the count memory, keeps the running maximum,
// holds the result in an output register; uses mflh_pkg
module mflh_scan
  import mflh_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [MASK_W-1:0]      excl_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  output mflh_rd_t               rd_o,
  output logic                   busy_o,
  output logic                   clr_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mflh_out_t              out_data_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   cmp_vld_q;
  logic [IDX_W-1:0]       cmp_idx_q;
  logic [COUNT_WIDTH-1:0] best_cnt_q, best_cnt_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic                   found_q, found_d;
  logic                   out_valid_q, out_valid_d;
  mflh_out_t              out_q, out_d;

  assign busy_o      = (state_q != ST_IDLE);
  assign rd_o.en     = (state_q == ST_SCAN);
  assign rd_o.addr   = idx_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    best_cnt_d  = best_cnt_q;
    best_idx_d  = best_idx_q;
    found_d     = found_q;
    out_d       = out_q;
    clr_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    // strict compare keeps the smaller index on ties
    if (cmp_vld_q && !is_excl(excl_i, cmp_idx_q) && cnt_i > best_cnt_q) begin
      best_cnt_d = cnt_i;
      best_idx_d = cmp_idx_q;
      found_d    = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d    = ST_SCAN;
          idx_d      = '0;
          best_cnt_d = '0;
          best_idx_d = '0;
          found_d    = 1'b0;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_IDX) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.best_letter = LETTER_W'(best_idx_q);
          out_d.found       = found_q;
          out_valid_d       = 1'b1;
          clr_o             = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmp_idx_q  <= idx_q;
    best_cnt_q <= best_cnt_d;
    best_idx_q <= best_idx_d;
    found_q    <= found_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= rd_o.en;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/most_frequent_letter_histogram_core.sv
// letter histogram with exclusion mask and most-frequent-letter readout
// top level; uses mflh_pkg, mflh_cnt_ram, mflh_scan
//
// input channel (in_valid_i / in_stall_o / in_data_i): a count transfer adds
// one to the counter of its letter unless the letter is out of range or
// excluded; count transfers are taken one per cycle, back to back, while no
// walk is under way. a finish transfer starts a walk over the 26 counters,
// one memory read per cycle; the input stalls after it through the scan,
// drain and done states, and the result then shows on out_valid_o.
// output channel (out_valid_o / out_stall_i / out_data_o): one result per
// finish; it sits in an output register and holds while out_stall_i is high.
// if a previous result is still stalled when the walk ends, the input stays
// stalled until that result is taken. count transfers go on while a result
// waits. counters saturate, and are cleared after each finish.
// register at byte address 0 over the apb port: excluded_letters.
// reset clears all counters, the mask and both valid flags; no clearing
// pass is needed after reset.
module most_frequent_letter_histogram_core
  import mflh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mflh_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mflh_out_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [MASK_W-1:0]      mask_q;
  logic                   busy;
  logic                   accept;
  logic                   hit;
  logic [IDX_W-1:0]       in_idx;
  logic                   upd_vld_q;
  logic [IDX_W-1:0]       upd_idx_q;
  logic [COUNT_WIDTH-1:0] cnt;
  logic                   clr;
  mflh_rd_t               scan_rd;
  mflh_rd_t               rd;
  mflh_wr_t               wr;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXCLUDED) ? DATA_W'(mask_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXCLUDED) begin
      mask_q <= pwdata[MASK_W-1:0] & keep_mask();
    end
  end

  // count path: read at accept, register the letter, then increment and write back
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_idx     = IDX_W'(in_data_i.letter);
  assign hit        = accept && in_data_i.kind == KIND_COUNT
                      && 32'(in_data_i.letter) < ALPHABET_SIZE
                      && !is_excl(mask_q, in_idx);

  always_ff @(posedge clk_i) begin
    if (hit) upd_idx_q <= in_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_vld_q <= 1'b0;
    end else begin
      upd_vld_q <= hit;
    end
  end

  assign wr.en   = upd_vld_q;
  assign wr.addr = upd_idx_q;
  assign wr.data = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;

  // count reads only while idle, scan reads only while busy
  assign rd.en   = busy ? scan_rd.en : hit;
  assign rd.addr = busy ? scan_rd.addr : in_idx;

  mflh_cnt_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .wr_i      (wr),
    .clr_i     (clr),
    .rd_data_o (cnt)
  );

  mflh_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && in_data_i.kind == KIND_FINISH),
    .excl_i      (mask_q),
    .cnt_i       (cnt),
    .rd_o        (scan_rd),
    .busy_o      (busy),
    .clr_o       (clr),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/mflh_checker.sv
// port-level checks for the letter histogram, bound to the top level
// uses mflh_pkg and most_frequent_letter_histogram_core_defines.svh
`include "most_frequent_letter_histogram_core_defines.svh"

module mflh_port_checker
  import mflh_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input mflh_in_t          in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mflh_out_t         out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  `MFLH_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled result changed")

  `MFLH_ASSERT_NOW(a_not_found_zero, out_valid_o && !out_data_o.found,
                   out_data_o.best_letter == '0, "best_letter nonzero without found")

  `MFLH_ASSERT_NOW(a_letter_range, out_valid_o && out_data_o.found,
                   32'(out_data_o.best_letter) < ALPHABET_SIZE, "best_letter out of range")

  `MFLH_ASSERT_NEXT(a_finish_stalls,
                    in_valid_i && !in_stall_o && in_data_i.kind == KIND_FINISH,
                    in_stall_o, "input not stalled during finish walk")

endmodule

bind most_frequent_letter_histogram_core mflh_port_checker u_mflh_checker (.*);

FILE: tb/mflh_checker.sv
`timescale 1ns / 1ps
// checker for the letter histogram: watches the input, output and apb write traffic,
// keeps its own letter tallies and exclusion mask, compares each result transfer
// depends on mflh_pkg
module mflh_checker
  import mflh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  mflh_in_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  mflh_out_t         out_data_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                pending_o,
  output int                fail_count_o
);

  logic [COUNT_WIDTH-1:0] tally [ALPHABET_SIZE];
  logic [MASK_W-1:0]      skip_mask;
  mflh_out_t              best_q [$];

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // highest tally among letters not masked off, ties to the lower index
  function automatic mflh_out_t pick_most_frequent();
    mflh_out_t              res;
    logic [COUNT_WIDTH-1:0] top_count;
    res       = '0;
    top_count = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (!skip_mask[i] && tally[i] > top_count) begin
        top_count       = tally[i];
        res.best_letter = LETTER_W'(i);
        res.found       = 1'b1;
      end
    end
    return res;
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    mflh_out_t want;
    if (!rst_ni) begin
      foreach (tally[i]) tally[i] = '0;
      skip_mask = '0;
      best_q.delete();
    end else begin
      // result side first so a same-cycle finish cannot match itself
      if (out_valid_i && !out_stall_i) begin
        if (best_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected (letter %0d found %0b)",
                                    out_data_i.best_letter, out_data_i.found));
        end else begin
          want = best_q.pop_front();
          if (out_data_i.best_letter !== want.best_letter)
            report_mismatch($sformatf("best_letter got %0d want %0d",
                                      out_data_i.best_letter, want.best_letter));
          if (out_data_i.found !== want.found)
            report_mismatch($sformatf("found got %0b want %0b", out_data_i.found, want.found));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.kind == KIND_COUNT) begin
          if (in_data_i.letter < ALPHABET_SIZE && !skip_mask[in_data_i.letter] &&
              tally[in_data_i.letter] != COUNT_MAX)
            tally[in_data_i.letter] = tally[in_data_i.letter] + 1'b1;
        end else begin
          best_q.push_back(pick_most_frequent());
          foreach (tally[i]) tally[i] = '0;
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_W'(4 * int'(REG_EXCLUDED)))
        skip_mask = pwdata[MASK_W-1:0];
    end
    pending_o = best_q.size();
  end

endmodule

FILE: tb/tb_most_frequent_letter_histogram_core.sv
`timescale 1ns / 1ps
// stimulus and verdict for most_frequent_letter_histogram_core
// depends on mflh_pkg, the core and mflh_checker
module tb_most_frequent_letter_histogram_core;
  import mflh_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  mflh_in_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  mflh_out_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                pending;
  int                fail_count;
  int                send_idle_pct;
  int                stall_pct;

  most_frequent_letter_histogram_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mflh_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i   (in_stall_o),
    .in_data_i,
    .out_valid_i  (out_valid_o),
    .out_stall_i,
    .out_data_i   (out_data_o),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  initial begin
    #16_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [LETTER_W-1:0] letter);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= mflh_in_t'{kind: kind, letter: letter};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // all results in, then let a trailing count transfer settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_exclusions(input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_EXCLUDED));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int                  list_left;
    int                  sent;
    int                  r;
    logic [LETTER_W-1:0] fav [3];
    logic [LETTER_W-1:0] letter;
    logic [DATA_W-1:0]   mask;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list, letter field ignored on finish
    send_item(KIND_FINISH, 5'd31);
    // end letters and out-of-range letters
    send_item(KIND_COUNT, 5'd0);
    send_item(KIND_COUNT, 5'd25);
    send_item(KIND_COUNT, 5'd25);
    send_item(KIND_COUNT, 5'd31);
    send_item(KIND_COUNT, 5'd26);
    send_item(KIND_FINISH, 5'd0);
    // tie goes to the lower letter
    send_item(KIND_COUNT, 5'd3);
    send_item(KIND_COUNT, 5'd1);
    send_item(KIND_COUNT, 5'd3);
    send_item(KIND_COUNT, 5'd1);
    send_item(KIND_FINISH, 5'd17);
    // letter A found, not to be confused with not found
    send_item(KIND_COUNT, 5'd0);
    send_item(KIND_FINISH, 5'd0);
    // everything excluded, upper write bits dropped
    wait_idle();
    write_exclusions(32'hFFFF_FFFF);
    send_item(KIND_COUNT, 5'd5);
    send_item(KIND_COUNT, 5'd6);
    send_item(KIND_FINISH, 5'd0);
    // exclusion added after counting, before the finish
    wait_idle();
    write_exclusions('0);
    send_item(KIND_COUNT, 5'd4);
    send_item(KIND_COUNT, 5'd4);
    send_item(KIND_COUNT, 5'd9);
    wait_idle();
    write_exclusions(32'(1) << 4);
    send_item(KIND_COUNT, 5'd4);
    send_item(KIND_FINISH, 5'd0);

    list_left = 0;
    foreach (fav[i]) fav[i] = LETTER_W'($urandom_range(25));
    for (int sub = 0; sub < 8; sub++) begin
      wait_idle();
      case (sub)
        0, 7:    mask = '0;
        1:       mask = 32'hFFFF_FFFF;
        2:       mask = $urandom;
        3:       mask = 32'(1) << $urandom_range(25);
        4:       mask = ~(32'(1) << $urandom_range(25));
        5:       mask = $urandom & $urandom;
        default: mask = 32'h03FF_FFFF;
      endcase
      write_exclusions(mask);
      case (sub / 2)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 47; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      // a list in progress carries over the mask write
      sent = 0;
      while (sent < 160) begin
        if (list_left == 0 || $urandom_range(99) < 3) begin
          send_item(KIND_FINISH, LETTER_W'($urandom_range(31)));
          list_left = $urandom_range(40);
          foreach (fav[i]) fav[i] = LETTER_W'($urandom_range(25));
        end else begin
          r = $urandom_range(99);
          if (r < 10)
            letter = LETTER_W'($urandom_range(31));
          else if (r < 75)
            letter = fav[$urandom_range(2)];
          else
            letter = LETTER_W'($urandom_range(25));
          send_item(KIND_COUNT, letter);
          list_left--;
        end
        sent++;
      end
    end
    send_item(KIND_FINISH, 5'd0);

    wait_idle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
